@@ hw/rtl/fixed_capacity_array_list_unit_assert.svh @@
// assertion macros for the array list unit checker
// depends on nothing; included by files that hold concurrent assertions
`ifndef FIXED_CAPACITY_ARRAY_LIST_UNIT_ASSERT_SVH
`define FIXED_CAPACITY_ARRAY_LIST_UNIT_ASSERT_SVH

// condition that must hold at every edge out of reset
`define FCAL_ASSERT_NOW(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed: %m");

// antecedent this cycle implies consequent on the next edge
`define FCAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

@@ hw/rtl/fcal_pkg.sv @@
// shared types, codes and constants of the array list unit
// depends on nothing; imported by every module of the block
package fcal_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int VALUE_W          = 32;
  localparam logic [4:0] LIMIT_RESET = 5'd16;

  // request codes
  localparam logic [3:0] REQ_INS_FIRST = 4'd0;
  localparam logic [3:0] REQ_INS_LAST  = 4'd1;
  localparam logic [3:0] REQ_INS_MID   = 4'd2;
  localparam logic [3:0] REQ_INS_AT    = 4'd3;
  localparam logic [3:0] REQ_DEL_FIRST = 4'd4;
  localparam logic [3:0] REQ_DEL_LAST  = 4'd5;
  localparam logic [3:0] REQ_DEL_MID   = 4'd6;
  localparam logic [3:0] REQ_DEL_AT    = 4'd7;
  localparam logic [3:0] REQ_SEARCH    = 4'd8;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [3:0]                req_type;
    logic signed [VALUE_W-1:0] value;
    logic [3:0]                position;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] found_index;
    logic [4:0] entry_count;
  } out_word_t;

  // what every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } fsm_state_t;

endpackage

@@ hw/rtl/fcal_cell.sv @@
// one slot of the list chain: holds an entry and trades it with its neighbors
// depends on fcal_pkg
module fcal_cell import fcal_pkg::*; #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_cmd_t          cmd,
  input  logic [IW-1:0]      at,
  input  logic [VALUE_W-1:0] left_i,
  input  logic [VALUE_W-1:0] right_i,
  output logic [VALUE_W-1:0] data_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;

  // insert shifts up from the left, delete and rotate pull from the right
  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CELL_INS: begin
        if (MY_IDX > at) begin
          data_nxt = left_i;
        end else if (MY_IDX == at) begin
          data_nxt = cmd.value;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= at) begin
          data_nxt = right_i;
        end
      end
      CELL_ROT: data_nxt = right_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_o = data_r;

endmodule

@@ hw/rtl/fcal_out_buf.sv @@
// result register with one skid slot behind it
// depends on fcal_pkg
module fcal_out_buf import fcal_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_word_t push_word,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  out_word_t skid_word_r, skid_word_nxt;
  logic      drain;

  assign drain = out_valid_r && out_ready;

  // new word goes to the output slot when it frees up, else to the skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_word_nxt   = out_word_r;
    skid_word_nxt  = skid_word_r;
    if (drain) begin
      out_valid_nxt  = skid_valid_r;
      out_word_nxt   = skid_word_r;
      skid_valid_nxt = 1'b0;
    end
    if (push) begin
      if (!out_valid_r || drain) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = push_word;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_word_nxt  = push_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign room      = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ hw/rtl/fixed_capacity_array_list_unit.sv @@
// top level of the packed array list: controller, cell chain and result buffer
// depends on fcal_pkg, fcal_cell and fcal_out_buf
//
//   channel  dir  handshake              word
//   in_      in   in_valid / in_ready    in_word_t (req_type, value, position)
//   out_     out  out_valid / out_ready  out_word_t (status, found_index, entry_count)
//   cfg_     in   cfg_wr_en              cfg_wr_data (capacity_limit)
//
// inserts, deletes and unknown requests complete on acceptance: every cell shifts at once
// a search scans the chain: it rotates once through a comparator at cell 0
// reset is synchronous and clears all cells, the count and the limit (to 16)
// one result can wait in the skid slot; in_ready is low while it is held and during a scan
module fixed_capacity_array_list_unit import fcal_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_word,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > 5) ? CW : 5;
  localparam logic [XW-1:0] CAP_X   = XW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IX = IW'(CAPACITY - 1);

  fsm_state_t state_r, state_nxt;

  logic [4:0]         limit_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [IW-1:0]      k_r, k_nxt;
  logic               found_r, found_nxt;
  logic [IW-1:0]      fidx_r, fidx_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;

  logic               scanning;
  logic               room;
  logic               acc;
  logic               push;
  out_word_t          push_word;
  cell_cmd_t          cmd;
  logic [IW-1:0]      at_idx;

  logic [XW-1:0]      cnt_x, lim_x, eff_x, pos_x, half_x, at_x;
  logic [XW-1:0]      cnt_out_x, fidx_out_x;
  logic [IW-1:0]      sel_idx;
  logic               is_ins, is_del, is_search;
  logic               match, last;
  logic [2:0]         status;

  logic [VALUE_W-1:0] cell_q  [CAPACITY];
  logic [VALUE_W-1:0] left_w  [CAPACITY];
  logic [VALUE_W-1:0] right_w [CAPACITY];

  assign acc = in_valid && in_ready;

  // capacity limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc && in_word.req_type == REQ_SEARCH) state_nxt = S_SCAN;
      S_SCAN: if (last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    scanning = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = room;
      S_SCAN:  scanning = 1'b1;
      default: ;
    endcase
  end

  // request decode and target index
  assign cnt_x  = XW'(cnt_r);
  assign lim_x  = XW'(limit_r);
  assign eff_x  = (lim_x > CAP_X) ? CAP_X : lim_x;
  assign pos_x  = XW'(in_word.position);
  assign half_x = cnt_x >> 1;

  assign is_ins    = in_word.req_type <= REQ_INS_AT;
  assign is_del    = !is_ins && in_word.req_type <= REQ_DEL_AT;
  assign is_search = in_word.req_type == REQ_SEARCH;

  always_comb begin
    case (in_word.req_type)
      REQ_INS_LAST:  at_x = cnt_x;
      REQ_INS_MID:   at_x = half_x;
      REQ_DEL_LAST:  at_x = cnt_x - XW'(1);
      REQ_DEL_MID:   at_x = (half_x != '0) ? half_x - XW'(1) : '0;
      REQ_INS_AT, REQ_DEL_AT: at_x = pos_x;
      default:       at_x = '0;
    endcase
  end

  assign at_idx = at_x[IW-1:0];

  // immediate status, cell command and new count
  always_comb begin
    status    = ST_OK;
    cmd.op    = CELL_HOLD;
    cmd.value = in_word.value;
    cnt_nxt   = cnt_r;
    if (scanning) begin
      cmd.op = CELL_ROT;
    end else if (acc && is_ins) begin
      if (cnt_x >= eff_x) begin
        status = ST_FULL;
      end else if (at_x > cnt_x) begin
        status = ST_BADPOS;
      end else begin
        cmd.op  = CELL_INS;
        cnt_nxt = cnt_r + CW'(1);
      end
    end else if (acc && is_del) begin
      if (cnt_r == '0) begin
        status = ST_EMPTY;
      end else if (at_x >= cnt_x) begin
        status = ST_BADPOS;
      end else begin
        cmd.op  = CELL_DEL;
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  // search scan: cell 0 shows entry k on scan step k
  assign match = (cell_q[0] == key_r) && (XW'(k_r) < cnt_x);
  assign last  = scanning && (k_r == LAST_IX);

  always_comb begin
    k_nxt     = k_r;
    found_nxt = found_r;
    fidx_nxt  = fidx_r;
    key_nxt   = key_r;
    if (acc && is_search) begin
      k_nxt     = '0;
      found_nxt = 1'b0;
      key_nxt   = in_word.value;
    end else if (scanning) begin
      k_nxt = k_r + IW'(1);
      if (match && !found_r) begin
        found_nxt = 1'b1;
        fidx_nxt  = k_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      found_r <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fidx_r <= fidx_nxt;
    key_r  <= key_nxt;
  end

  // result word
  assign sel_idx    = found_r ? fidx_r : k_r;
  assign fidx_out_x = XW'(sel_idx);
  assign cnt_out_x  = XW'(cnt_nxt);
  assign push       = (acc && !is_search) || last;

  always_comb begin
    push_word.entry_count = cnt_out_x[4:0];
    if (last) begin
      push_word.status      = (found_r || match) ? ST_OK : ST_NOTFOUND;
      push_word.found_index = (found_r || match) ? fidx_out_x[3:0] : 4'd0;
    end else begin
      push_word.status      = status;
      push_word.found_index = 4'd0;
    end
  end

  // cell chain; the top cell pulls zero on delete and cell 0 on rotate
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w[g] = (cmd.op == CELL_ROT) ? cell_q[0] : '0;
    end else begin : g_mid_r
      assign right_w[g] = cell_q[g+1];
    end

    fcal_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .at      (at_idx),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .data_o  (cell_q[g])
    );
  end

  fcal_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

@@ hw/rtl/fcal_checker.sv @@
// port-level checks of the array list unit and the bind that attaches them
// depends on fcal_pkg and fixed_capacity_array_list_unit_assert.svh
`include "fixed_capacity_array_list_unit_assert.svh"

module fcal_checker import fcal_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // a stalled result word holds
  `FCAL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(out_word))

  // a search keeps the block busy in the following cycle
  `FCAL_ASSERT_NEXT(a_search_busy, clk, rst_n,
                    in_valid && in_ready && in_word.req_type == REQ_SEARCH, !in_ready)

  // empty status always comes with a zero count
  `FCAL_ASSERT_NOW(a_empty_count, clk, rst_n,
                   !(out_valid && out_word.status == ST_EMPTY) || out_word.entry_count == 5'd0)

  // a nonzero index only comes with a hit
  `FCAL_ASSERT_NOW(a_index_ok, clk, rst_n,
                   !(out_valid && out_word.found_index != 4'd0) || out_word.status == ST_OK)

endmodule

bind fixed_capacity_array_list_unit fcal_checker u_fcal_checker (.*);

@@ bench/fixed_capacity_array_list_unit_test.sv @@
// self-checking bench for the packed array list unit: directed and random request words
// depends on fcal_pkg and fixed_capacity_array_list_unit; checks every result word in order
module fixed_capacity_array_list_unit_test;
  import fcal_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = CAPACITY_DEFAULT;
  localparam int SETTLE       = LIST_DEPTH + 4;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 850;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_word;
  logic       cfg_wr_en;
  logic [4:0] cfg_wr_data;

  // shadow copy of the list and its limit
  logic [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
  int unsigned        shadow_count;
  logic [4:0]         shadow_limit;

  out_word_t   awaited_words[$];
  int unsigned mismatch_total;
  int unsigned stall_left;
  bit          steady;

  fixed_capacity_array_list_unit #(
    .CAPACITY(LIST_DEPTH)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // effect of one request on the shadow list, returns the result word it causes
  function automatic out_word_t list_apply(in_word_t w);
    out_word_t   r;
    int unsigned lim;
    int unsigned at;
    bit          hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    lim = (shadow_limit > LIST_DEPTH) ? LIST_DEPTH : shadow_limit;
    case (w.req_type)
      REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_MID, REQ_INS_AT: begin
        if (shadow_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          case (w.req_type)
            REQ_INS_FIRST: at = 0;
            REQ_INS_LAST:  at = shadow_count;
            REQ_INS_MID:   at = shadow_count / 2;
            default:       at = w.position;
          endcase
          if (at > shadow_count) begin
            r.status = ST_BADPOS;
          end else begin
            for (int i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[at] = w.value;
            shadow_count++;
          end
        end
      end
      REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_MID, REQ_DEL_AT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          case (w.req_type)
            REQ_DEL_FIRST: at = 0;
            REQ_DEL_LAST:  at = shadow_count - 1;
            REQ_DEL_MID:   at = (shadow_count / 2 >= 1) ? shadow_count / 2 - 1 : 0;
            default:       at = w.position;
          endcase
          if (at >= shadow_count) begin
            r.status = ST_BADPOS;
          end else begin
            for (int i = at; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
            shadow_entries[shadow_count-1] = '0;
            shadow_count--;
          end
        end
      end
      REQ_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_entries[i] == w.value) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_index = i[3:0];
          end
        end
      end
      default: begin
        // unknown request: no change
      end
    endcase
    r.entry_count = shadow_count[4:0];
    return r;
  endfunction

  // predict at each accepted word, then check each delivered result word
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < LIST_DEPTH; i++) shadow_entries[i] = '0;
      shadow_count = 0;
      shadow_limit = LIMIT_RESET;
    end else begin
      if (in_valid && in_ready) awaited_words.push_back(list_apply(in_word));
      if (cfg_wr_en) shadow_limit = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= REPORT_LIMIT)
            $display("unexpected result word: status %0d index %0d count %0d",
                     out_word.status, out_word.found_index, out_word.entry_count);
        end else begin
          want = awaited_words.pop_front();
          if (out_word !== want) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_LIMIT)
              $display("result mismatch: expected status %0d index %0d count %0d, got %0d %0d %0d",
                       want.status, want.found_index, want.entry_count,
                       out_word.status, out_word.found_index, out_word.entry_count);
          end
        end
      end
    end
  end

  // gap length for either side: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  initial begin
    out_ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // run watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // offer one word, hold it until taken, then maybe idle
  task automatic send_word(in_word_t w);
    int unsigned gap;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_request(logic [3:0] op, logic [VALUE_W-1:0] v, logic [3:0] pos);
    in_word_t w;
    w.req_type = op;
    w.value    = v;
    w.position = pos;
    send_word(w);
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limit(logic [4:0] lim);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random request word, insert share set by ins_pct
  function automatic in_word_t random_request(int unsigned ins_pct);
    in_word_t    w;
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(0, 99);
    if (roll < 3) w.req_type = 4'($urandom_range(REQ_SEARCH + 1, 15));
    else if (roll < 23) w.req_type = REQ_SEARCH;
    else if ($urandom_range(0, 99) < ins_pct)
      w.req_type = 4'($urandom_range(REQ_INS_FIRST, REQ_INS_AT));
    else w.req_type = 4'($urandom_range(REQ_DEL_FIRST, REQ_DEL_AT));
    // values: often one already held, sometimes small, else any 32 bits
    roll = $urandom_range(0, 99);
    if (roll < 40 && shadow_count > 0) w.value = shadow_entries[$urandom_range(0, shadow_count - 1)];
    else if (roll < 70) w.value = $signed($urandom_range(0, 7)) - 4;
    else w.value = $urandom;
    top = (shadow_count > 15) ? 15 : shadow_count;
    if ($urandom_range(0, 9) < 7) w.position = 4'($urandom_range(0, top));
    else w.position = 4'($urandom_range(0, 15));
    return w;
  endfunction

  task automatic test_empty_list();
    send_request(REQ_SEARCH, '0, '0);
    send_request(REQ_DEL_FIRST, '0, '0);
    send_request(REQ_DEL_LAST, '0, '0);
    send_request(REQ_DEL_MID, '0, '0);
    send_request(REQ_DEL_AT, '0, 4'hF);
    send_request(4'(REQ_SEARCH + 1), 32'h1234_5678, '0);
    send_request(4'hF, '1, 4'hF);
  endtask

  // zero limit: every insert is full, position not looked at
  task automatic test_zero_limit();
    set_limit(5'd0);
    send_request(REQ_INS_FIRST, 32'd1, '0);
    send_request(REQ_INS_AT, 32'd2, 4'hF);
  endtask

  // small list: extreme values, append by position, bad position, full, search
  task automatic test_small_list();
    set_limit(5'd3);
    send_request(REQ_INS_LAST, 32'h7FFF_FFFF, '0);
    send_request(REQ_INS_FIRST, 32'h8000_0000, '0);
    send_request(REQ_INS_AT, 32'd9, 4'd3);
    send_request(REQ_INS_AT, '1, 4'd2);
    send_request(REQ_INS_MID, 32'd5, '0);
    send_request(REQ_SEARCH, '1, '0);
    send_request(REQ_SEARCH, 32'h8000_0000, '0);
    send_request(REQ_SEARCH, 32'd5, '0);
  endtask

  // limit above depth, then lowered below the count; duplicate search, deletes
  task automatic test_lowered_limit();
    set_limit(5'd31);
    send_request(REQ_INS_MID, 32'h8000_0000, '0);
    set_limit(5'd1);
    send_request(REQ_INS_LAST, 32'd3, '0);
    send_request(REQ_SEARCH, 32'h8000_0000, '0);
    send_request(REQ_DEL_AT, '0, 4'd4);
    send_request(REQ_DEL_MID, '0, '0);
    send_request(REQ_DEL_AT, '0, 4'd0);
    send_request(REQ_DEL_LAST, '0, '0);
    send_request(REQ_DEL_FIRST, '0, '0);
  endtask

  // random phases over several limits, swinging between growth and shrinkage
  task automatic test_random_mix();
    logic [4:0]  limits [10];
    int unsigned per_phase;
    int unsigned sent;
    in_word_t    w;
    limits = '{5'd16, 5'd31, 5'd1, 5'd8, 5'd17, 5'd0, 5'd3, 5'd16, 5'd12, 5'd2};
    per_phase = RANDOM_ITEMS / 10;
    foreach (limits[p]) begin
      set_limit(limits[p]);
      sent = 0;
      while (sent < per_phase) begin
        steady = ((sent / 30) % 4 == 3);
        w = random_request(((sent / 30) % 2 == 0) ? 75 : 25);
        send_word(w);
        if (w.req_type <= REQ_SEARCH) sent++;
        // hold off until the list has caught up
        if (sent == per_phase / 2) wait_idle();
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_word        <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    mismatch_total = 0;
    steady         = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_zero_limit();
    test_small_list();
    test_lowered_limit();
    test_random_mix();

    wait_idle();
    if (mismatch_total == 0 && awaited_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
